@@ sv/bsb_pkg.sv @@
package bsb_pkg;

	// action codes of an input item
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	// loop counter and knot offset widths, sized for the largest supported degree
	localparam int J_W   = 4;
	localparam int OFF_W = 5;

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// divider: |num| << 16 over |den|, one quotient bit per cycle
	localparam int NUM_W     = 33;
	localparam int DVD_W     = 49;
	localparam int DIV_STEPS = 49;
	localparam int CNT_W     = 6;

	localparam logic [15:0] THR_RESET = 16'd7;

	typedef enum logic [4:0] {
		S_IDLE,
		S_Z_RD0,
		S_Z_RD1,
		S_Z_CAP,
		S_Z_WR,
		S_R_RD0,
		S_R_RD1,
		S_R_RD2,
		S_R_RD3,
		S_R_CAP,
		S_R_D1,
		S_R_W1,
		S_R_D2,
		S_R_W2,
		S_R_M1,
		S_R_T1,
		S_R_M2,
		S_R_T2,
		S_R_WR,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_T0,
		CAP_T1,
		CAP_TR,
		CAP_TR1
	} cap_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LEFT,
		MUL_RIGHT
	} mul_t;

	typedef enum logic [1:0] {
		TRN_NONE,
		TRN_A,
		TRN_B
	} trn_t;

	typedef enum logic {
		LV_INTERVAL,
		LV_SUM
	} lv_src_t;

	typedef enum logic {
		DIV_LEFT,
		DIV_RIGHT
	} div_sel_t;

	typedef struct packed {
		logic             kn_rd;
		logic [OFF_W-1:0] kn_off;
		cap_t             cap;
		logic             lv_rd;
		logic             lv_wr;
		lv_src_t          lv_src;
		logic [J_W-1:0]   lv_j;
		logic             div_start;
		div_sel_t         div_sel;
		logic             cap_f1;
		logic             cap_f2;
		mul_t             mul;
		trn_t             trn;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

@@ sv/bsb_div.sv @@
module bsb_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [bsb_pkg::NUM_W-1:0]  num,
	input  logic signed [bsb_pkg::NUM_W-1:0]  den,
	input  logic [15:0]                       thr,
	output logic                              done,
	output logic signed [31:0]                quo
);
	import bsb_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [NUM_W-1:0] dm_q;
	logic [NUM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             neg_q;
	logic             one_q;

	logic [NUM_W-1:0] num_mag;
	logic [NUM_W-1:0] den_mag;
	logic             den_small;
	logic [NUM_W:0]   rem_t;
	logic             q_bit;

	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign den_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
	// a span that counts as zero takes factor one
	assign den_small = (den_mag == '0) || (den_mag < NUM_W'(thr));

	assign rem_t = {rem_q, dvd_q[DVD_W-1]};
	assign q_bit = rem_t >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= !den_small;
				done_q <= den_small;
			end else if (run_q && cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			one_q <= den_small;
			neg_q <= num[NUM_W-1] ^ den[NUM_W-1];
			dvd_q <= {num_mag, 16'd0};
			dm_q  <= den_mag;
			rem_q <= '0;
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (run_q) begin
			rem_q <= q_bit ? NUM_W'(rem_t - {1'b0, dm_q}) : NUM_W'(rem_t);
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		if (one_q) begin
			quo = Q_ONE;
		end else if (neg_q) begin
			if (dvd_q > DVD_W'(33'h0_8000_0000)) quo = S32_MIN;
			else quo = 32'(-dvd_q);
		end else begin
			if (dvd_q > DVD_W'(33'h0_7FFF_FFFF)) quo = S32_MAX;
			else quo = dvd_q[31:0];
		end
	end

	assign done = done_q;

endmodule

@@ sv/bsb_datapath.sv @@
module bsb_datapath #(
	parameter int MAX_KNOTS  = 64,
	parameter int MAX_DEGREE = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	input  logic [5:0]          knot_index,
	input  logic signed [31:0]  knot_value,
	input  logic [5:0]          span_index,
	input  logic signed [31:0]  param_u,
	input  logic                cfg_wr,
	input  logic [15:0]         cfg_data,
	input  bsb_pkg::cmd_t       cmd,
	output bsb_pkg::sts_t       sts,
	output logic signed [31:0]  res
);
	import bsb_pkg::*;

	localparam int KW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int LW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;

	logic signed [31:0] knot_mem [MAX_KNOTS];
	logic signed [31:0] lv_mem [MAX_DEGREE + 1];

	logic [15:0]        thr_q;
	logic signed [31:0] u_q;
	logic [KW-1:0]      i_q;
	logic signed [31:0] kd_q;
	logic signed [31:0] t0_q, t1_q, tr_q, tr1_q;
	logic signed [31:0] lva_q, lvb_q;
	logic signed [31:0] f1_q, f2_q;
	logic signed [63:0] prod_q;
	logic signed [47:0] a_q, b_q;
	logic signed [31:0] res_q;

	logic [KW-1:0]      kn_addr;
	logic [LW-1:0]      lv_addr;
	logic [LW-1:0]      lv_addr_nx;
	logic signed [NUM_W-1:0] div_num, div_den;
	logic               div_done;
	logic signed [31:0] div_quo;
	logic signed [31:0] mul_x, mul_y;
	logic signed [63:0] prod_sh;
	logic signed [47:0] trunc_v;
	logic signed [48:0] sum_v;
	logic signed [31:0] sum_sat;
	logic signed [31:0] lv_wdata;

	assign kn_addr    = i_q + KW'(cmd.kn_off);
	assign lv_addr    = LW'(cmd.lv_j);
	assign lv_addr_nx = LW'(cmd.lv_j + J_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_wr) thr_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_WRITE && 32'(knot_index) < MAX_KNOTS)
			knot_mem[KW'(knot_index)] <= knot_value;
		if (cmd.kn_rd) kd_q <= knot_mem[kn_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.lv_wr) lv_mem[lv_addr] <= lv_wdata;
		if (cmd.lv_rd) begin
			lva_q <= lv_mem[lv_addr];
			lvb_q <= lv_mem[lv_addr_nx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_EVAL) begin
			u_q <= param_u;
			i_q <= KW'(span_index);
		end
		case (cmd.cap)
			CAP_T0:  t0_q  <= kd_q;
			CAP_T1:  t1_q  <= kd_q;
			CAP_TR:  tr_q  <= kd_q;
			CAP_TR1: tr1_q <= kd_q;
			default: ;
		endcase
		if (cmd.cap_f1) f1_q <= div_quo;
		if (cmd.cap_f2) f2_q <= div_quo;
		if (cmd.mul != MUL_NONE) prod_q <= mul_x * mul_y;
		case (cmd.trn)
			TRN_A:   a_q <= trunc_v;
			TRN_B:   b_q <= trunc_v;
			default: ;
		endcase
		if (cmd.lv_wr) res_q <= lv_wdata;
	end

	// left factor (u - t0)/(tr - t0), right factor (tr1 - u)/(tr1 - t1)
	always_comb begin
		if (cmd.div_sel == DIV_LEFT) begin
			div_num = {u_q[31], u_q} - {t0_q[31], t0_q};
			div_den = {tr_q[31], tr_q} - {t0_q[31], t0_q};
		end else begin
			div_num = {tr1_q[31], tr1_q} - {u_q[31], u_q};
			div_den = {tr1_q[31], tr1_q} - {t1_q[31], t1_q};
		end
	end

	bsb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.thr    (thr_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign mul_x = (cmd.mul == MUL_RIGHT) ? f2_q : f1_q;
	assign mul_y = (cmd.mul == MUL_RIGHT) ? lvb_q : lva_q;

	// product / 65536 rounded toward zero
	assign prod_sh = prod_q >>> 16;
	assign trunc_v = prod_sh[47:0] + 48'(prod_q[63] && prod_q[15:0] != 16'd0);

	assign sum_v = {a_q[47], a_q} + {b_q[47], b_q};

	always_comb begin
		if (sum_v > 49'sh0_7FFF_FFFF) sum_sat = S32_MAX;
		else if (sum_v < -49'sh0_8000_0000) sum_sat = S32_MIN;
		else sum_sat = sum_v[31:0];
	end

	always_comb begin
		if (cmd.lv_src == LV_INTERVAL)
			lv_wdata = (u_q >= t0_q && u_q < t1_q) ? Q_ONE : 32'sd0;
		else
			lv_wdata = sum_sat;
	end

	assign sts.div_done = div_done;
	assign res = res_q;

endmodule

@@ sv/bsb_ctrl.sv @@
module bsb_ctrl #(
	parameter int MAX_KNOTS  = 64,
	parameter int MAX_DEGREE = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          action,
	input  logic [5:0]    span_index,
	input  logic [2:0]    degree,
	input  bsb_pkg::sts_t sts,
	output bsb_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output logic          err
);
	import bsb_pkg::*;

	state_t         state_q, state_d;
	logic [J_W-1:0] k_q, j_q, j_d, r_q, r_d;
	logic           err_q;
	logic           err_in;

	assign err_in = (32'(degree) > MAX_DEGREE) ||
		(32'(span_index) + 32'(degree) + 32'd1 >= MAX_KNOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= 1'b0;
			k_q     <= '0;
			j_q     <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			r_q     <= r_d;
			if (accept && action == ACT_EVAL) begin
				err_q <= err_in;
				k_q   <= J_W'(degree);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		r_d     = r_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && action == ACT_EVAL) begin
					j_d     = '0;
					r_d     = '0;
					state_d = err_in ? S_DONE : S_Z_RD0;
				end
			end
			S_Z_RD0: begin
				cmd.kn_rd  = 1'b1;
				cmd.kn_off = OFF_W'(j_q);
				state_d    = S_Z_RD1;
			end
			S_Z_RD1: begin
				cmd.kn_rd  = 1'b1;
				cmd.kn_off = OFF_W'(j_q) + OFF_W'(1);
				cmd.cap    = CAP_T0;
				state_d    = S_Z_CAP;
			end
			S_Z_CAP: begin
				cmd.cap = CAP_T1;
				state_d = S_Z_WR;
			end
			S_Z_WR: begin
				cmd.lv_wr  = 1'b1;
				cmd.lv_src = LV_INTERVAL;
				cmd.lv_j   = j_q;
				if (j_q == k_q) begin
					j_d = '0;
					r_d = J_W'(1);
					state_d = (k_q == '0) ? S_DONE : S_R_RD0;
				end else begin
					j_d     = j_q + J_W'(1);
					state_d = S_Z_RD0;
				end
			end
			S_R_RD0: begin
				cmd.kn_rd  = 1'b1;
				cmd.kn_off = OFF_W'(j_q);
				cmd.lv_rd  = 1'b1;
				cmd.lv_j   = j_q;
				state_d    = S_R_RD1;
			end
			S_R_RD1: begin
				cmd.kn_rd  = 1'b1;
				cmd.kn_off = OFF_W'(j_q) + OFF_W'(1);
				cmd.cap    = CAP_T0;
				state_d    = S_R_RD2;
			end
			S_R_RD2: begin
				cmd.kn_rd  = 1'b1;
				cmd.kn_off = OFF_W'(j_q) + OFF_W'(r_q);
				cmd.cap    = CAP_T1;
				state_d    = S_R_RD3;
			end
			S_R_RD3: begin
				cmd.kn_rd  = 1'b1;
				cmd.kn_off = OFF_W'(j_q) + OFF_W'(r_q) + OFF_W'(1);
				cmd.cap    = CAP_TR;
				state_d    = S_R_CAP;
			end
			S_R_CAP: begin
				cmd.cap = CAP_TR1;
				state_d = S_R_D1;
			end
			S_R_D1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_LEFT;
				state_d       = S_R_W1;
			end
			S_R_W1: begin
				if (sts.div_done) begin
					cmd.cap_f1 = 1'b1;
					state_d    = S_R_D2;
				end
			end
			S_R_D2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_RIGHT;
				state_d       = S_R_W2;
			end
			S_R_W2: begin
				if (sts.div_done) begin
					cmd.cap_f2 = 1'b1;
					state_d    = S_R_M1;
				end
			end
			S_R_M1: begin
				cmd.mul = MUL_LEFT;
				state_d = S_R_T1;
			end
			S_R_T1: begin
				cmd.trn = TRN_A;
				state_d = S_R_M2;
			end
			S_R_M2: begin
				cmd.mul = MUL_RIGHT;
				state_d = S_R_T2;
			end
			S_R_T2: begin
				cmd.trn = TRN_B;
				state_d = S_R_WR;
			end
			S_R_WR: begin
				cmd.lv_wr  = 1'b1;
				cmd.lv_src = LV_SUM;
				cmd.lv_j   = j_q;
				// last entry of this level
				if (J_W'(j_q + r_q) == k_q) begin
					j_d = '0;
					if (r_q == k_q) begin
						state_d = S_DONE;
					end else begin
						r_d     = r_q + J_W'(1);
						state_d = S_R_RD0;
					end
				end else begin
					j_d     = j_q + J_W'(1);
					state_d = S_R_RD0;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
	assign err  = err_q;

endmodule

@@ sv/bspline_basis_evaluator.sv @@
// B-spline basis evaluator, Cox-de Boor recurrence in signed Q16.16.
// Command channel: an item transfers on a clock edge with start high and busy
// low. action 0 writes knot_value at knot_index (no result, busy stays low),
// action 1 evaluates N(span_index, degree, param_u) and yields one result.
// Result: basis_value and status appear for one cycle with done high; the
// receiver takes every result and cannot stall the block.
// Config channel: cfg_data (zero_span_threshold) transfers when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Sequence: an evaluate with a bad span or degree reports status 1 in the cycle
// right after its transfer. Otherwise the level-zero tests read the two knots
// of each interval and write its indicator, and each of the k(k+1)/2 recurrence
// steps takes 4 knot reads, two divisions on the serial divider (shortened when
// the knot span counts as zero), two multiplies, two truncations and a sum.
// Both divisions of a step share the one divider.
// One item is in flight at a time; busy is high until done.
// Reset: the threshold returns to 7 and the control goes idle; knots are
// undefined until written.
module bspline_basis_evaluator #(
	parameter int MAX_KNOTS  = 64,
	parameter int MAX_DEGREE = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [5:0]         knot_index,
	input  logic signed [31:0] knot_value,
	input  logic [5:0]         span_index,
	input  logic [2:0]         degree,
	input  logic signed [31:0] param_u,
	output logic               done,
	output logic signed [31:0] basis_value,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import bsb_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic               accept;
	logic               err;
	logic signed [31:0] res;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	bsb_ctrl #(
		.MAX_KNOTS  (MAX_KNOTS),
		.MAX_DEGREE (MAX_DEGREE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.span_index (span_index),
		.degree     (degree),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.err        (err)
	);

	bsb_datapath #(
		.MAX_KNOTS  (MAX_KNOTS),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.knot_index (knot_index),
		.knot_value (knot_value),
		.span_index (span_index),
		.param_u    (param_u),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.res        (res)
	);

	assign basis_value = err ? 32'sd0 : res;
	assign status      = err;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_WRITE |=> !busy && !done)
		else $error("knot write started work");

	a_bad_span: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_EVAL &&
		(32'(span_index) + 32'(degree) + 32'd1 >= MAX_KNOTS) |=> done && status)
		else $error("bad span not reported at once");

endmodule

@@ tb/tb.sv @@
module tb;
	import bsb_pkg::*;

	localparam int N_KNOTS  = 64;
	localparam int WD_LIMIT = 20000;

	typedef struct {
		logic               act;
		logic [5:0]         kidx;
		logic signed [31:0] kval;
		logic [5:0]         span;
		logic [2:0]         deg;
		logic signed [31:0] u;
		bit                 typed;
		logic signed [31:0] val;
		logic               st;
	} dir_row_t;

	typedef struct {
		logic signed [31:0] val;
		logic               st;
	} basis_res_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [5:0]         knot_index;
	logic signed [31:0] knot_value;
	logic [5:0]         span_index;
	logic [2:0]         degree;
	logic signed [31:0] param_u;
	logic               done;
	logic signed [31:0] basis_value;
	logic               status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        cfg_data;

	logic signed [31:0] knot_mem [N_KNOTS];
	logic [15:0]        span_thr;
	basis_res_t         basis_expect [$];
	int                 errors;
	int                 idle_cycles;

	dir_row_t dir_tab [20] = '{
		'{ACT_EVAL, 0, 0, 0, 0, 0, 1, 32'sh0001_0000, 0},
		'{ACT_EVAL, 0, 0, 63, 0, 0, 1, 0, 1},
		'{ACT_EVAL, 0, 0, 56, 7, 0, 1, 0, 1},
		'{ACT_EVAL, 0, 0, 63, 7, 32'sh7FFF_FFFF, 1, 0, 1},
		'{ACT_EVAL, 0, 0, 55, 7, 32'sh003B_0000, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 0, 1, 32'sh0000_8000, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 3, 2, 32'sh0004_4000, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 10, 3, 32'sh000C_1234, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 20, 4, 32'sh0017_0000, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 30, 5, 32'sh0021_8000, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 40, 6, 32'sh002B_0001, 0, 0, 0},
		'{ACT_WRITE, 63, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0},
		'{ACT_WRITE, 62, 32'sh8000_0000, 0, 0, 0, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 62, 0, 32'sh8000_0000, 1, 32'sh0001_0000, 0},
		'{ACT_EVAL, 0, 0, 61, 1, 32'sh7FFF_FFFE, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 60, 2, 32'sh8000_0000, 0, 0, 0},
		'{ACT_WRITE, 1, 0, 0, 0, 0, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 0, 0, 32'sh7FFF_FFFF, 1, 0, 0},
		'{ACT_EVAL, 0, 0, 0, 1, 0, 0, 0, 0},
		'{ACT_EVAL, 0, 0, 0, 2, 32'sh0001_8000, 0, 0, 0}
	};

	bspline_basis_evaluator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.knot_index (knot_index),
		.knot_value (knot_value),
		.span_index (span_index),
		.degree     (degree),
		.param_u    (param_u),
		.done       (done),
		.basis_value(basis_value),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// knot spans below the threshold count as zero and give a factor of one
	function automatic longint span_factor(longint num, longint den);
		longint mag;
		mag = den < 0 ? -den : den;
		if (den == 0 || mag < longint'(span_thr))
			return longint'(Q_ONE);
		return sat32((num * longint'(Q_ONE)) / den);
	endfunction

	function automatic basis_res_t cox_de_boor(int i, int k, longint u);
		basis_res_t res;
		longint     lv [8];
		longint     t0, t1, tr, tr1, a, b;
		if (i + k + 1 >= N_KNOTS) begin
			res.val = 0;
			res.st  = 1'b1;
			return res;
		end
		for (int j = 0; j <= k; j++)
			lv[j] = (u >= knot_mem[i+j] && u < knot_mem[i+j+1]) ? longint'(Q_ONE) : 0;
		for (int r = 1; r <= k; r++) begin
			for (int j = 0; j + r <= k; j++) begin
				t0  = knot_mem[i+j];
				t1  = knot_mem[i+j+1];
				tr  = knot_mem[i+j+r];
				tr1 = knot_mem[i+j+r+1];
				a = (span_factor(u - t0, tr - t0) * lv[j]) / longint'(Q_ONE);
				b = (span_factor(tr1 - u, tr1 - t1) * lv[j+1]) / longint'(Q_ONE);
				lv[j] = sat32(a + b);
			end
		end
		res.val = lv[0][31:0];
		res.st  = 1'b0;
		return res;
	endfunction

	// drive one item and return at the edge where it transfers; start stays high
	task automatic send_item(logic act, logic [5:0] kidx, logic signed [31:0] kval,
			logic [5:0] span, logic [2:0] deg, logic signed [31:0] u,
			bit typed, logic signed [31:0] tval, logic tst);
		int         gap;
		basis_res_t res;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		action     <= act;
		knot_index <= kidx;
		knot_value <= kval;
		span_index <= span;
		degree     <= deg;
		param_u    <= u;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		if (act == ACT_WRITE) begin
			knot_mem[kidx] = kval;
		end else begin
			res = cox_de_boor(span, deg, u);
			if (typed) begin
				res.val = tval;
				res.st  = tst;
			end
			basis_expect.push_back(res);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		wait (basis_expect.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] thr);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= thr;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
		end
		@(posedge clk);
		span_thr = thr;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		basis_res_t exp_res;
		if (done) begin
			if (basis_expect.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value %h status %b", $time,
					basis_value, status);
			end else begin
				exp_res = basis_expect.pop_front();
				if (basis_value !== exp_res.val) begin
					errors++;
					$display("%0t: basis_value expected %h actual %h", $time,
						exp_res.val, basis_value);
				end
				if (status !== exp_res.st) begin
					errors++;
					$display("%0t: status expected %b actual %b", $time,
						exp_res.st, status);
				end
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int                 sent, i, k, mode;
		logic [15:0]        thr;
		logic signed [31:0] cur, u, lo, hi;
		errors      = 0;
		idle_cycles = 0;
		span_thr    = THR_RESET;
		start       = 1'b0;
		action      = ACT_WRITE;
		knot_index  = '0;
		knot_value  = '0;
		span_index  = '0;
		degree      = '0;
		param_u     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// uniform knots at the integers so no evaluate reads an unwritten entry
		for (int n = 0; n < N_KNOTS; n++)
			send_item(ACT_WRITE, 6'(n), 32'(n << 16), 6'd0, 3'd0, 32'sd0, 0, 32'sd0, 1'b0);
		foreach (dir_tab[n])
			send_item(dir_tab[n].act, dir_tab[n].kidx, dir_tab[n].kval, dir_tab[n].span,
				dir_tab[n].deg, dir_tab[n].u, dir_tab[n].typed, dir_tab[n].val,
				dir_tab[n].st);

		sent = 0;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: thr = 16'd0;
				1: thr = 16'hFFFF;
				2: thr = 16'd7;
				default: thr = 16'($urandom_range(0, 16'hFFFF));
			endcase
			write_threshold(thr);
			for (int n = 0; n < 36; ) begin
				k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 7);
				i = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, 62 - k);
				mode = $urandom_range(0, 9);
				if (mode < 6 && i + k + 1 < N_KNOTS) begin
					// nondecreasing window with repeats and tiny spans
					cur = $signed($urandom_range(0, 16)) - 8 <<< 16;
					for (int j = 0; j <= k + 1; j++) begin
						send_item(ACT_WRITE, 6'(i + j), cur, 6'($urandom), 3'($urandom),
							32'($urandom), 0, 32'sd0, 1'b0);
						n++;
						case ($urandom_range(0, 7))
							0: cur = cur;
							1: cur = cur + $urandom_range(1, 40);
							2: cur = cur + $urandom_range(16'hFF00, 16'hFFFF);
							default: cur = cur + $urandom_range(16'h4000, 32'h3_0000);
						endcase
					end
				end else if (mode < 8) begin
					send_item(ACT_WRITE, 6'($urandom_range(0, 63)), 32'($urandom),
						6'($urandom), 3'($urandom), 32'($urandom), 0, 32'sd0, 1'b0);
					n++;
				end
				if (i + k + 1 < N_KNOTS) begin
					lo = knot_mem[i];
					hi = knot_mem[i+k+1];
				end else begin
					lo = 0;
					hi = 0;
				end
				if ($urandom_range(0, 9) == 0 || hi <= lo)
					u = $urandom;
				else
					u = lo + ($urandom % (hi - lo));
				send_item(ACT_EVAL, 6'($urandom), 32'($urandom), 6'(i), 3'(k), u,
					0, 32'sd0, 1'b0);
				n++;
			end
		end
		drain_results();
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

@@ sim.f @@
sv/bsb_pkg.sv
sv/bsb_div.sv
sv/bsb_datapath.sv
sv/bsb_ctrl.sv
sv/bspline_basis_evaluator.sv
tb/tb.sv
